[rtl/prescaled_updown_timer_pair_defines.svh]
// Assertion macros shared by the timer pair RTL.
// No dependencies; included by files that carry concurrent checks.
`ifndef PRESCALED_UPDOWN_TIMER_PAIR_DEFINES_SVH
`define PRESCALED_UPDOWN_TIMER_PAIR_DEFINES_SVH

// Same-cycle implication, disabled during reset
`define PUT_ASSERT_SAME(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, disabled during reset
`define PUT_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) else $error(msg);

`endif

[rtl/put_pkg.sv]
// Package for the prescaled up/down timer pair: opcodes, register map, bits.
// No dependencies.
package put_pkg;

  // Request opcodes
  typedef enum logic [1:0] {
    OP_READ  = 2'd0,
    OP_WRITE = 2'd1,
    OP_TICK  = 2'd2
  } op_t;

  localparam int unsigned ADDR_W   = 7;
  localparam int unsigned DATA_W   = 32;
  localparam int unsigned OFF_W    = 6;
  localparam int unsigned STRIDE   = 36;

  // Per-timer register offsets
  localparam logic [OFF_W-1:0] OFF_CONFIG  = 6'h00;
  localparam logic [OFF_W-1:0] OFF_LO      = 6'h04;
  localparam logic [OFF_W-1:0] OFF_HI      = 6'h08;
  localparam logic [OFF_W-1:0] OFF_UPDATE  = 6'h0c;
  localparam logic [OFF_W-1:0] OFF_LOAD_LO = 6'h18;
  localparam logic [OFF_W-1:0] OFF_LOAD_HI = 6'h1c;
  localparam logic [OFF_W-1:0] OFF_LOAD    = 6'h20;

  // Config and update bit positions
  localparam int unsigned EN_BIT     = 31;
  localparam int unsigned UP_BIT     = 30;
  localparam int unsigned LATCH_BIT  = 31;
  localparam int unsigned DIVRST_BIT = 12;
  localparam int unsigned DIV_LSB    = 13;

  // Command from the decoder to one timer
  typedef struct packed {
    logic              tick;
    logic              wr;
    logic [OFF_W-1:0]  off;
    logic [DATA_W-1:0] wdata;
  } timer_cmd_t;

endpackage

[rtl/put_chan_if.sv]
// Handshake channels for the timer pair: bus request and read response.
// Depends on put_pkg for widths.
interface put_req_if import put_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [1:0]        op;
  logic [ADDR_W-1:0] reg_addr;
  logic [DATA_W-1:0] write_data;

  modport source (output valid, op, reg_addr, write_data, input ready);
  modport sink   (input valid, op, reg_addr, write_data, output ready);
endinterface

interface put_rsp_if import put_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [DATA_W-1:0] read_data;

  modport source (output valid, read_data, input ready);
  modport sink   (input valid, read_data, output ready);
endinterface

[rtl/put_timer.sv]
// One prescaled up/down timer: count, snapshot, load and config registers.
// Depends on put_pkg (register map, timer_cmd_t).
module put_timer import put_pkg::*; #(
  parameter int unsigned COUNT_WIDTH   = 54,
  parameter int unsigned DIVIDER_WIDTH = 16
) (
  input  logic              clk,
  input  logic              rst_n,
  input  timer_cmd_t        cmd,
  output logic [DATA_W-1:0] rd_data
);

  localparam int unsigned CW   = COUNT_WIDTH;
  localparam int unsigned DW   = DIVIDER_WIDTH;
  localparam int unsigned HI_W = CW - 32;

  logic [CW-1:0]     count_r;
  logic [CW-1:0]     snap_r;
  logic [CW-1:0]     load_r;
  logic [DATA_W-1:0] ctrl_r;
  logic [DW-1:0]     pre_r;

  logic [DW-1:0] div_fld;
  logic [DW:0]   div_eff;
  logic [DW:0]   pre_inc;
  logic          step;
  logic [CW-1:0] count_step;

  // Effective divider: 0 means 2^DW, 1 acts as 2
  assign div_fld = ctrl_r[DIV_LSB +: DW];
  always_comb begin
    priority if (div_fld == '0) begin
      div_eff = {1'b1, {DW{1'b0}}};
    end else if (div_fld == DW'(1)) begin
      div_eff = (DW+1)'(2);
    end else begin
      div_eff = {1'b0, div_fld};
    end
  end

  assign pre_inc    = {1'b0, pre_r} + (DW+1)'(1);
  assign step       = (pre_inc >= div_eff);
  assign count_step = ctrl_r[UP_BIT] ? count_r + CW'(1) : count_r - CW'(1);

  // State update: tick and write never come together
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
      snap_r  <= '0;
      load_r  <= '0;
      ctrl_r  <= '0;
      pre_r   <= '0;
    end else if (cmd.tick) begin
      if (ctrl_r[EN_BIT]) begin
        if (step) begin
          pre_r   <= '0;
          count_r <= count_step;
        end else begin
          pre_r <= pre_inc[DW-1:0];
        end
      end
    end else if (cmd.wr) begin
      unique case (cmd.off)
        OFF_CONFIG: begin
          ctrl_r <= cmd.wdata & ~(DATA_W'(1) << DIVRST_BIT);
          if (cmd.wdata[DIVRST_BIT]) begin
            pre_r <= '0;
          end
        end
        OFF_UPDATE: begin
          if (cmd.wdata[LATCH_BIT]) begin
            snap_r <= count_r;
          end
        end
        OFF_LOAD_LO: load_r[31:0]    <= cmd.wdata;
        OFF_LOAD_HI: load_r[CW-1:32] <= cmd.wdata[HI_W-1:0];
        OFF_LOAD:    count_r         <= load_r;
        default: ;
      endcase
    end
  end

  // Register read mux
  always_comb begin
    unique case (cmd.off)
      OFF_CONFIG:  rd_data = ctrl_r;
      OFF_LO:      rd_data = snap_r[31:0];
      OFF_HI:      rd_data = DATA_W'(snap_r[CW-1:32]);
      OFF_LOAD_LO: rd_data = load_r[31:0];
      OFF_LOAD_HI: rd_data = DATA_W'(load_r[CW-1:32]);
      default:     rd_data = '0;
    endcase
  end

endmodule

[rtl/prescaled_updown_timer_pair.sv]
// Top level of the prescaled up/down timer pair: request register, decode,
// timers and response register. Depends on put_pkg, put_chan_if, put_timer.
//
//   channel  dir  payload                          handshake
//   in_chan  in   op, reg_addr, write_data         valid/ready
//   out_chan out  read_data                        valid/ready
//
// One request per cycle while out_chan is ready: a request is held in the
// request register, is decoded and applied to the timers, and its response
// lands in the output register.
// The request register keeps accepting while a response waits; it stalls
// only when both registers are full and out_chan is not ready.
// Reset is synchronous and clears all timer state to zero.
`include "prescaled_updown_timer_pair_defines.svh"

module prescaled_updown_timer_pair import put_pkg::*; #(
  parameter int unsigned NUM_TIMERS    = 2,
  parameter int unsigned COUNT_WIDTH   = 54,
  parameter int unsigned DIVIDER_WIDTH = 16
) (
  input  logic      clk,
  input  logic      rst_n,
  put_req_if.sink   in_chan,
  put_rsp_if.source out_chan
);

  logic              s1_valid_r;
  logic [1:0]        s1_op_r;
  logic [ADDR_W-1:0] s1_addr_r;
  logic [DATA_W-1:0] s1_data_r;
  logic              out_valid_r;
  logic [DATA_W-1:0] out_data_r;

  logic              adv;
  logic              in_ready;
  logic              aligned;
  logic [DATA_W-1:0] result;

  logic              hit     [NUM_TIMERS];
  logic [DATA_W-1:0] rd_data [NUM_TIMERS];
  timer_cmd_t        cmd     [NUM_TIMERS];

  // Handshake: advance stage one when the output register is free or drains
  assign adv      = s1_valid_r && (!out_valid_r || out_chan.ready);
  assign in_ready = !s1_valid_r || adv;
  assign in_chan.ready = in_ready;

  // Request register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ready) begin
      s1_valid_r <= in_chan.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_chan.valid) begin
      s1_op_r   <= in_chan.op;
      s1_addr_r <= in_chan.reg_addr;
      s1_data_r <= in_chan.write_data;
    end
  end

  assign aligned = (s1_addr_r[1:0] == 2'b00);

  // Address decode and one timer per slot
  for (genvar n = 0; n < NUM_TIMERS; n++) begin : g_timer
    localparam logic [ADDR_W-1:0] BASE = ADDR_W'(n * STRIDE);
    localparam logic [ADDR_W:0]   TOP  = (ADDR_W+1)'((n + 1) * STRIDE);
    logic [ADDR_W-1:0] rel;

    assign hit[n] = (s1_addr_r >= BASE) && ({1'b0, s1_addr_r} < TOP);
    assign rel    = s1_addr_r - BASE;

    assign cmd[n].tick  = adv && (s1_op_r == OP_TICK);
    assign cmd[n].wr    = adv && (s1_op_r == OP_WRITE) && aligned && hit[n];
    assign cmd[n].off   = rel[OFF_W-1:0];
    assign cmd[n].wdata = s1_data_r;

    put_timer #(
      .COUNT_WIDTH  (COUNT_WIDTH),
      .DIVIDER_WIDTH(DIVIDER_WIDTH)
    ) u_timer (
      .clk    (clk),
      .rst_n  (rst_n),
      .cmd    (cmd[n]),
      .rd_data(rd_data[n])
    );
  end

  // Read result: zero for writes, ticks and unmapped offsets
  always_comb begin
    result = '0;
    for (int n = 0; n < NUM_TIMERS; n++) begin
      if ((s1_op_r == OP_READ) && aligned && hit[n]) begin
        result = result | rd_data[n];
      end
    end
  end

  // Response register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= 1'b1;
    end else if (out_chan.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_data_r <= result;
    end
  end

  assign out_chan.valid     = out_valid_r;
  assign out_chan.read_data = out_data_r;

  // Checks
  `PUT_ASSERT_SAME(a_full_stall, clk, rst_n, s1_valid_r && out_valid_r && !out_chan.ready, !in_ready, "request taken while both stages are full")
  `PUT_ASSERT_NEXT(a_adv_valid, clk, rst_n, adv, out_valid_r, "advanced request produced no response")
  `PUT_ASSERT_NEXT(a_nonread_zero, clk, rst_n, adv && (s1_op_r != OP_READ), out_data_r == '0, "non-read request returned nonzero data")

endmodule
